### hdl/ppa_pkg.sv
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared constants and types for the per-CPU page allocator.
// ----------------------------------------------------------------------------
package ppa_pkg;

    localparam int ADDR_W      = 40;
    localparam int CPU_FIELD_W = 3;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 1;

    localparam int DEF_NUM_CPUS    = 8;
    localparam int DEF_NUM_PAGES   = 32768;
    localparam int DEF_STEAL_LIMIT = 64;
    localparam int DEF_PAGE_BYTES  = 4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OOM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_START = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_END   = 1'b1;

    localparam logic [ADDR_W-1:0] REGION_START_RST = 40'd0;
    localparam logic [ADDR_W-1:0] REGION_END_RST   = 40'd134217728;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] limit;
    } region_t;

endpackage

### hdl/ppa_link_ram.sv
// ----------------------------------------------------------------------------
// ppa_link_ram
// Next-link memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ppa_link_ram #(
    parameter int DEPTH  = ppa_pkg::DEF_NUM_PAGES,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/ppa_ctrl.sv
// ----------------------------------------------------------------------------
// ppa_ctrl
// Sequencer for push, pop and steal; holds the per-CPU list heads and the
// result register.
// ----------------------------------------------------------------------------
module ppa_ctrl #(
    parameter int NUM_CPUS    = ppa_pkg::DEF_NUM_CPUS,
    parameter int NUM_PAGES   = ppa_pkg::DEF_NUM_PAGES,
    parameter int STEAL_LIMIT = ppa_pkg::DEF_STEAL_LIMIT,
    parameter int PAGE_BYTES  = ppa_pkg::DEF_PAGE_BYTES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ppa_pkg::region_t                    region,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_op,
    input  logic [ppa_pkg::CPU_FIELD_W-1:0]     in_cpu,
    input  logic [ppa_pkg::ADDR_W-1:0]          in_addr,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ppa_pkg::ADDR_W-1:0]          out_addr,
    output logic [ppa_pkg::STATUS_W-1:0]        out_status
);

    localparam int AW  = ppa_pkg::ADDR_W;
    localparam int PW  = $clog2(NUM_PAGES);
    localparam int LW  = $clog2(NUM_PAGES + 1);
    localparam int CW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int NW  = $clog2(NUM_CPUS + 1);
    localparam int SW  = $clog2(STEAL_LIMIT + 1);
    localparam int PS  = $clog2(PAGE_BYTES);
    localparam int PNW = AW - PS;
    localparam logic [CW-1:0] CPU_LAST = CW'(NUM_CPUS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP,
        S_LOOK,
        S_MOVE,
        S_END,
        S_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic                        op_reg, op_next;
    logic [CW-1:0]               cpu_reg, cpu_next;
    logic [AW-1:0]               pa_reg, pa_next;
    logic                        stolen_reg, stolen_next;
    logic [LW-1:0]               work_reg, work_next;
    logic [LW-1:0]               cur_reg, cur_next;
    logic [CW-1:0]               victim_reg, victim_next;
    logic [NW-1:0]               cnt_reg, cnt_next;
    logic [SW-1:0]               left_reg, left_next;
    logic [AW-1:0]               res_addr_reg, res_addr_next;
    logic [ppa_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                        out_valid_reg, out_valid_next;
    logic [AW-1:0]               out_addr_reg, out_addr_next;
    logic [ppa_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [LW-1:0]               head_reg [NUM_CPUS];

    logic                        head_we;
    logic [CW-1:0]               head_widx;
    logic [LW-1:0]               head_wdata;
    logic [CW-1:0]               head_ridx;
    logic [LW-1:0]               head_rd;

    logic                        ram_we;
    logic [PW-1:0]               ram_waddr;
    logic [LW-1:0]               ram_wdata;
    logic                        ram_re;
    logic [PW-1:0]               ram_raddr;
    logic [LW-1:0]               ram_rdata;

    logic [4:0]                  cpu_rem;
    logic [CW-1:0]               cpu_in_mod;
    logic [PNW-1:0]              page_num;
    logic                        free_ok;
    logic [LW-1:0]               push_link;
    logic [LW-1:0]               head_m1;
    logic [LW-1:0]               cur_m1;
    logic                        out_free;
    logic                        accept;

    function automatic logic [CW-1:0] cpu_succ(input logic [CW-1:0] c);
        logic [CW-1:0] r;
        r = (c == CPU_LAST) ? '0 : c + CW'(1);
        return r;
    endfunction

    ppa_link_ram #(
        .DEPTH  (NUM_PAGES),
        .ADDR_W (PW),
        .DATA_W (LW)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // reduce the CPU field modulo the CPU count
    always_comb
    begin
        cpu_rem = {2'b00, in_cpu};
        for (int i = 0; i < 8; i++)
        begin
            if (cpu_rem >= 5'(NUM_CPUS))
            begin
                cpu_rem = cpu_rem - 5'(NUM_CPUS);
            end
        end
        cpu_in_mod = cpu_rem[CW-1:0];
    end

    assign head_ridx = (state_reg == S_LOOK) ? victim_reg : cpu_reg;
    assign head_rd   = head_reg[head_ridx];
    assign head_m1   = head_rd - LW'(1);
    assign cur_m1    = cur_reg - LW'(1);

    assign page_num  = pa_reg[AW-1:PS];
    assign free_ok   = (pa_reg[PS-1:0] == '0) && (pa_reg >= region.start) &&
                       (pa_reg < region.limit) && (page_num < PNW'(NUM_PAGES));
    assign push_link = LW'(page_num[PW-1:0]) + LW'(1);

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) || ((state_reg == S_DONE) && out_free);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        cpu_next        = cpu_reg;
        pa_next         = pa_reg;
        stolen_next     = stolen_reg;
        work_next       = work_reg;
        cur_next        = cur_reg;
        victim_next     = victim_reg;
        cnt_next        = cnt_reg;
        left_next       = left_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        head_we         = 1'b0;
        head_widx       = cpu_reg;
        head_wdata      = work_reg;
        ram_we          = 1'b0;
        ram_waddr       = cur_m1[PW-1:0];
        ram_wdata       = work_reg;
        ram_re          = 1'b0;
        ram_raddr       = head_m1[PW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = in_op;
                    cpu_next    = cpu_in_mod;
                    pa_next     = in_addr;
                    stolen_next = 1'b0;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_addr_next = '0;
                if (op_reg == ppa_pkg::OP_FREE)
                begin
                    if (free_ok)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = page_num[PW-1:0];
                        ram_wdata       = head_rd;
                        head_we         = 1'b1;
                        head_wdata      = push_link;
                        res_status_next = ppa_pkg::STATUS_OK;
                    end
                    else
                    begin
                        res_status_next = ppa_pkg::STATUS_BAD;
                    end
                    state_next = S_DONE;
                end
                else if (head_rd != '0)
                begin
                    ram_re     = 1'b1;
                    cur_next   = head_rd;
                    state_next = S_POP;
                end
                else if (stolen_reg)
                begin
                    res_status_next = ppa_pkg::STATUS_OOM;
                    state_next      = S_DONE;
                end
                else
                begin
                    work_next   = '0;
                    left_next   = SW'(STEAL_LIMIT);
                    victim_next = cpu_succ(cpu_reg);
                    cnt_next    = NW'(1);
                    state_next  = S_LOOK;
                end
            end
            S_POP:
            begin
                head_we         = 1'b1;
                head_wdata      = ram_rdata;
                res_addr_next   = AW'(cur_m1) << PS;
                res_status_next = ppa_pkg::STATUS_OK;
                state_next      = S_DONE;
            end
            S_LOOK:
            begin
                if ((left_reg == '0) || (cnt_reg == NW'(NUM_CPUS)))
                begin
                    state_next = S_END;
                end
                else if (head_rd == '0)
                begin
                    victim_next = cpu_succ(victim_reg);
                    cnt_next    = cnt_reg + NW'(1);
                end
                else
                begin
                    ram_re     = 1'b1;
                    cur_next   = head_rd;
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                // unlink from the victim, push onto the requester's list
                head_we    = 1'b1;
                head_widx  = victim_reg;
                head_wdata = ram_rdata;
                ram_we     = 1'b1;
                work_next  = cur_reg;
                left_next  = left_reg - SW'(1);
                state_next = S_LOOK;
            end
            S_END:
            begin
                head_we     = 1'b1;
                stolen_next = 1'b1;
                state_next  = S_DISPATCH;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    if (accept)
                    begin
                        op_next     = in_op;
                        cpu_next    = cpu_in_mod;
                        pa_next     = in_addr;
                        stolen_next = 1'b0;
                        state_next  = S_DISPATCH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stolen_reg    <= 1'b0;
            cnt_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            stolen_reg    <= stolen_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
            if (head_we)
            begin
                head_reg[head_widx] <= head_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        cpu_reg        <= cpu_next;
        pa_reg         <= pa_next;
        work_reg       <= work_next;
        cur_reg        <= cur_next;
        victim_reg     <= victim_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_addr   = out_addr_reg;
    assign out_status = out_status_reg;

`ifndef SYNTH
    a_move_after_look: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MOVE |-> $past(state_reg) == S_LOOK)
        else $error("steal move not preceded by a list lookup");

    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= SW'(STEAL_LIMIT))
        else $error("steal budget above limit");

    a_ready_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE || state_reg == S_DONE))
        else $error("ready raised while a transaction is in progress");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |-> (cur_reg != '0 && $past(state_reg) == S_DISPATCH))
        else $error("pop of an empty list");
`endif

endmodule

### hdl/per_cpu_page_allocator_top.sv
// ----------------------------------------------------------------------------
// per_cpu_page_allocator_top
// Page-frame allocator with one LIFO free list per CPU and work stealing.
// ----------------------------------------------------------------------------
// A free transaction passes from dispatch to the done state; an allocate
// served from the requester's own list passes through dispatch, pop and
// done. When that list is empty the block steals from the other CPUs first:
// each page moved is read and then written back through the single
// next-link memory, each empty CPU list is visited in turn, and the steal
// ends with a last list check and a head write-back, followed by an
// own-list allocate. Input is taken only between transactions, but a result
// may still wait in the output register while the next transaction is
// accepted. The link memory has no reset or clearing pass; the list heads
// reset to empty. Double frees are not detected.
// ----------------------------------------------------------------------------
module per_cpu_page_allocator_top #(
    parameter int NUM_CPUS    = ppa_pkg::DEF_NUM_CPUS,
    parameter int NUM_PAGES   = ppa_pkg::DEF_NUM_PAGES,
    parameter int STEAL_LIMIT = ppa_pkg::DEF_STEAL_LIMIT,
    parameter int PAGE_BYTES  = ppa_pkg::DEF_PAGE_BYTES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ppa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ppa_pkg::ADDR_W-1:0]          cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [47:0]                         s_axis_tdata,  // cpu[2:0], page_address[42:3]
    input  logic                                s_axis_tuser,  // op
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [39:0]                         m_axis_tdata,  // alloc_address[39:0]
    output logic [ppa_pkg::STATUS_W-1:0]        m_axis_tuser   // status[1:0]
);

    ppa_pkg::region_t region_reg, region_next;

    always_comb
    begin
        region_next = region_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ppa_pkg::CFG_REGION_START: region_next.start = cfg_data;
                ppa_pkg::CFG_REGION_END:   region_next.limit = cfg_data;
                default:                   region_next = region_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg.start <= ppa_pkg::REGION_START_RST;
            region_reg.limit <= ppa_pkg::REGION_END_RST;
        end
        else
        begin
            region_reg <= region_next;
        end
    end

    ppa_ctrl #(
        .NUM_CPUS    (NUM_CPUS),
        .NUM_PAGES   (NUM_PAGES),
        .STEAL_LIMIT (STEAL_LIMIT),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .region     (region_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tuser),
        .in_cpu     (s_axis_tdata[2:0]),
        .in_addr    (s_axis_tdata[42:3]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_addr   (m_axis_tdata),
        .out_status (m_axis_tuser)
    );

endmodule
